// ===== rtl/core/mcv_pkg.sv =====
// Shared types and constants for the maze carver.
`default_nettype none
package mcv_pkg;

  localparam int unsigned MaxCells = 1024;
  localparam int unsigned MaxSide  = 32;
  localparam int unsigned CellW    = $clog2(MaxCells);
  localparam int unsigned SideW    = 6;
  localparam int unsigned RemW     = $clog2(MaxSide);
  localparam int unsigned WallW    = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 10;

  typedef logic [CellW-1:0] cell_t;
  typedef logic [SideW-1:0] side_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GRID_ROWS  = 2'd0,
    REG_GRID_COLS  = 2'd1,
    REG_START_CELL = 2'd2,
    REG_END_CELL   = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    DIR_TOP    = 2'd0,
    DIR_RIGHT  = 2'd1,
    DIR_BOTTOM = 2'd2,
    DIR_LEFT   = 2'd3
  } dir_e;

  // Request bundle from the sequencer to the set/wall memories.
  typedef struct packed {
    logic             p_we;
    cell_t            p_waddr;
    cell_t            p_wdata;
    cell_t            p_raddr;
    logic             w_we;
    cell_t            w_waddr;
    logic [WallW-1:0] w_wdata;
    cell_t            w_raddr;
  } mem_req_t;

  typedef struct packed {
    cell_t            p_rdata;
    logic [WallW-1:0] w_rdata;
  } mem_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/core/mcv_if.sv =====
// Handshake interfaces for carve attempts and carve results.
`default_nettype none
interface mcv_in_if;
  logic       valid;
  logic       ready;
  logic [9:0] cell_index;
  logic [1:0] direction;
  modport source (output valid, output cell_index, output direction, input ready);
  modport sink   (input valid, input cell_index, input direction, output ready);
endinterface

interface mcv_out_if;
  logic        valid;
  logic        ready;
  logic        carved;
  logic [9:0]  chosen_cell;
  logic [9:0]  neighbour_cell;
  logic        done_res;
  logic        bad_cell;
  logic [31:0] attempt_count;
  modport source (output valid, output carved, output chosen_cell, output neighbour_cell,
                  output done_res, output bad_cell, output attempt_count, input ready);
  modport sink   (input valid, input carved, input chosen_cell, input neighbour_cell,
                  input done_res, input bad_cell, input attempt_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/mcv_mem.sv =====
// Parent and open-wall memories, one write and one registered read each.
`default_nettype none
module mcv_mem (
  input  wire               clk_i,
  input  wire mcv_pkg::mem_req_t req_i,
  output mcv_pkg::mem_rsp_t rsp_o
);
  import mcv_pkg::*;

  cell_t            parent_mem [MaxCells];
  logic [WallW-1:0] wall_mem   [MaxCells];
  cell_t            p_rdata_q;
  logic [WallW-1:0] w_rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.p_we) begin
      parent_mem[req_i.p_waddr] <= req_i.p_wdata;
    end
    p_rdata_q <= parent_mem[req_i.p_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.w_we) begin
      wall_mem[req_i.w_waddr] <= req_i.w_wdata;
    end
    w_rdata_q <= wall_mem[req_i.w_raddr];
  end

  assign rsp_o.p_rdata = p_rdata_q;
  assign rsp_o.w_rdata = w_rdata_q;
endmodule
`default_nettype wire

// ===== rtl/core/mcv_colmod.sv =====
// Bit-serial remainder of a cell index by the column count.
`default_nettype none
module mcv_colmod (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start_i,
  input  wire mcv_pkg::cell_t dividend_i,
  input  wire mcv_pkg::side_t divisor_i,
  output logic                done_o,
  output logic [mcv_pkg::RemW-1:0] rem_o
);
  import mcv_pkg::*;

  localparam int unsigned CntW = $clog2(CellW + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  cell_t            shift_q, shift_d;
  side_t            div_q, div_d;
  logic [RemW-1:0]  rem_q, rem_d;
  side_t            trial;

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    shift_d = shift_q;
    div_d   = div_q;
    rem_d   = rem_q;
    trial   = {rem_q, shift_q[CellW-1]};
    if (start_i) begin
      busy_d  = 1'b1;
      cnt_d   = '0;
      shift_d = dividend_i;
      div_d   = divisor_i;
      rem_d   = '0;
    end else if (busy_q) begin
      // shift in one dividend bit, subtract when it fits
      if (trial >= div_q) begin
        rem_d = RemW'(trial - div_q);
      end else begin
        rem_d = RemW'(trial);
      end
      shift_d = {shift_q[CellW-2:0], 1'b0};
      cnt_d   = CntW'(cnt_q + 1'b1);
      if (cnt_q == CntW'(CellW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    div_q   <= div_d;
    rem_q   <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;
endmodule
`default_nettype wire

// ===== rtl/core/random_kruskal_maze_carver.sv =====
// Randomized Kruskal maze carver: sequencer around the union-find memories.
//
// Channels: in_i takes carve attempt words (cell_index, direction); out_o returns
// one result word per attempt. Both use valid/ready; a word moves when both are high.
// Grid size and entry/exit cells are set through the write port (cfg_we_i,
// cfg_idx_i, cfg_data_i); the user must write them only while the block is
// idle, which the block itself does not enforce. After reset the block sweeps
// the parent and wall memories, one entry a cycle, over all 1024 entries;
// in_i.ready stays low during the sweep. One attempt at a time: the column
// remainder holds the sequencer while a bit-serial unit runs its 10 bit steps
// and then sets its done register. Each root search walks the parent memory
// one link per cycle, with up to six searches (entry, exit, both cells, entry
// and exit again) per attempt, so latency grows with tree depth of the sets involved.
// A finished result sits in the output register; the next attempt is accepted
// meanwhile, and the sequencer holds before writing a new result until the
// receiver has taken the old one.
`default_nettype none
module random_kruskal_maze_carver (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  mcv_in_if.sink                    in_i,
  mcv_out_if.source                 out_o,
  input  wire                       cfg_we_i,
  input  wire [mcv_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire [mcv_pkg::CfgDataW-1:0] cfg_data_i
);
  import mcv_pkg::*;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_MOD   = 9'b000000100,
    S_FIND  = 9'b000001000,
    S_BODY  = 9'b000010000,
    S_WALLA = 9'b000100000,
    S_WALLB = 9'b001000000,
    S_POST  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_e;

  typedef enum logic [2:0] {
    PH_PRE_S  = 3'd0,
    PH_PRE_E  = 3'd1,
    PH_CELL   = 3'd2,
    PH_NB     = 3'd3,
    PH_POST_S = 3'd4,
    PH_POST_E = 3'd5
  } phase_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;

  side_t  rows_q, cols_q;
  cell_t  start_q, end_q;
  cell_t  clr_q, clr_d;
  logic [31:0] attempts_q, attempts_d;

  cell_t  cell_q, cell_d;
  dir_e   dir_q, dir_d;
  logic   bad_q, bad_d;
  logic   has_q, has_d;
  cell_t  nb_q, nb_d;
  cell_t  find_x_q, find_x_d;
  cell_t  root_a_q, root_a_d;
  logic   pre_q, pre_d;
  logic   post_q, post_d;
  logic   carved_q, carved_d;

  logic        ov_q, ov_d;
  logic        o_carved_q, o_done_q, o_bad_q;
  cell_t       o_cell_q, o_nb_q;
  logic [31:0] o_att_q;
  logic        load_out;

  mem_req_t mreq;
  mem_rsp_t mrsp;
  logic     mod_start, mod_done;
  logic [RemW-1:0] col;

  side_t      rows_c, cols_c;
  logic [10:0] n_c;
  logic       ends_in;
  logic [10:0] cell_w, nb_w;
  logic       has_c;
  cell_t      root_lo, root_hi;

  function automatic side_t clamp_side(side_t v);
    if (v == '0) begin
      return side_t'(1);
    end else if (v > side_t'(MaxSide)) begin
      return side_t'(MaxSide);
    end
    return v;
  endfunction

  mcv_mem u_mem (
    .clk_i (clk_i),
    .req_i (mreq),
    .rsp_o (mrsp)
  );

  mcv_colmod u_colmod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (cell_d),
    .divisor_i  (cols_c),
    .done_o     (mod_done),
    .rem_o      (col)
  );

  assign rows_c  = clamp_side(rows_q);
  assign cols_c  = clamp_side(cols_q);
  assign n_c     = 11'(rows_c) * 11'(cols_c);
  assign ends_in = ({1'b0, start_q} < n_c) && ({1'b0, end_q} < n_c);
  assign cell_w  = {1'b0, cell_q};

  // neighbour across the chosen wall
  always_comb begin
    has_c = 1'b0;
    nb_w  = '0;
    case (dir_q)
      DIR_TOP: begin
        has_c = cell_w >= 11'(cols_c);
        nb_w  = 11'(cell_w - 11'(cols_c));
      end
      DIR_RIGHT: begin
        has_c = (6'(col) + 6'd1 < cols_c) && (11'(cell_w + 11'd1) < n_c);
        nb_w  = 11'(cell_w + 11'd1);
      end
      DIR_BOTTOM: begin
        has_c = 11'(cell_w + 11'(cols_c)) < n_c;
        nb_w  = 11'(cell_w + 11'(cols_c));
      end
      default: begin
        has_c = col != '0;
        nb_w  = 11'(cell_w - 11'd1);
      end
    endcase
  end

  assign root_lo = (root_a_q < mrsp.p_rdata) ? root_a_q : mrsp.p_rdata;
  assign root_hi = (root_a_q < mrsp.p_rdata) ? mrsp.p_rdata : root_a_q;

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    clr_d      = clr_q;
    attempts_d = attempts_q;
    cell_d     = cell_q;
    dir_d      = dir_q;
    bad_d      = bad_q;
    has_d      = has_q;
    nb_d       = nb_q;
    find_x_d   = find_x_q;
    root_a_d   = root_a_q;
    pre_d      = pre_q;
    post_d     = post_q;
    carved_d   = carved_q;
    mod_start  = 1'b0;
    load_out   = 1'b0;
    mreq       = '0;
    mreq.p_raddr = find_x_q;

    unique case (state_q)
      S_CLEAR: begin
        mreq.p_we    = 1'b1;
        mreq.p_waddr = clr_q;
        mreq.p_wdata = clr_q;
        mreq.w_we    = 1'b1;
        mreq.w_waddr = clr_q;
        mreq.w_wdata = '0;
        clr_d        = cell_t'(clr_q + 1'b1);
        if (clr_q == cell_t'(MaxCells - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_i.valid) begin
          cell_d   = in_i.cell_index;
          dir_d    = dir_e'(in_i.direction);
          carved_d = 1'b0;
          state_d  = S_MOD;
        end
      end
      S_MOD: begin
        if (mod_done) begin
          bad_d = cell_w >= n_c;
          has_d = has_c;
          nb_d  = cell_t'(nb_w);
          if (ends_in) begin
            mreq.p_raddr = start_q;
            find_x_d     = start_q;
            phase_d      = PH_PRE_S;
            state_d      = S_FIND;
          end else begin
            pre_d   = 1'b0;
            state_d = S_BODY;
          end
        end
      end
      S_FIND: begin
        if (mrsp.p_rdata != find_x_q) begin
          // follow the parent link
          find_x_d     = mrsp.p_rdata;
          mreq.p_raddr = mrsp.p_rdata;
        end else begin
          case (phase_q)
            PH_PRE_S: begin
              root_a_d     = find_x_q;
              mreq.p_raddr = end_q;
              find_x_d     = end_q;
              phase_d      = PH_PRE_E;
            end
            PH_PRE_E: begin
              pre_d   = root_a_q == find_x_q;
              state_d = S_BODY;
            end
            PH_CELL: begin
              root_a_d     = find_x_q;
              mreq.p_raddr = nb_q;
              find_x_d     = nb_q;
              phase_d      = PH_NB;
            end
            PH_NB: begin
              if (root_a_q != find_x_q) begin
                mreq.p_we    = 1'b1;
                mreq.p_waddr = root_hi;
                mreq.p_wdata = root_lo;
                mreq.w_raddr = cell_q;
                carved_d     = 1'b1;
                state_d      = S_WALLA;
              end else begin
                post_d  = pre_q;
                state_d = S_OUT;
              end
            end
            PH_POST_S: begin
              root_a_d     = find_x_q;
              mreq.p_raddr = end_q;
              find_x_d     = end_q;
              phase_d      = PH_POST_E;
            end
            default: begin
              post_d  = root_a_q == find_x_q;
              state_d = S_OUT;
            end
          endcase
        end
      end
      S_BODY: begin
        if (!pre_q) begin
          attempts_d = 32'(attempts_q + 32'd1);
        end
        if (pre_q || bad_q || !has_q) begin
          post_d  = pre_q;
          state_d = S_OUT;
        end else begin
          mreq.p_raddr = cell_q;
          find_x_d     = cell_q;
          phase_d      = PH_CELL;
          state_d      = S_FIND;
        end
      end
      S_WALLA: begin
        mreq.w_we    = 1'b1;
        mreq.w_waddr = cell_q;
        mreq.w_wdata = mrsp.w_rdata | (WallW'(1) << dir_q);
        mreq.w_raddr = nb_q;
        state_d      = S_WALLB;
      end
      S_WALLB: begin
        mreq.w_we    = 1'b1;
        mreq.w_waddr = nb_q;
        mreq.w_wdata = mrsp.w_rdata | (WallW'(1) << (dir_q ^ 2'd2));
        state_d      = S_POST;
      end
      S_POST: begin
        if (ends_in) begin
          mreq.p_raddr = start_q;
          find_x_d     = start_q;
          phase_d      = PH_POST_S;
          state_d      = S_FIND;
        end else begin
          post_d  = 1'b0;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_q || out_o.ready) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (state_q == S_IDLE && in_i.valid) begin
      mod_start = 1'b1;
    end
  end

  // hold the result until taken, load the next one behind it
  always_comb begin
    ov_d = ov_q;
    if (out_o.ready) begin
      ov_d = 1'b0;
    end
    if (load_out) begin
      ov_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      phase_q    <= PH_PRE_S;
      clr_q      <= '0;
      attempts_q <= '0;
      ov_q       <= 1'b0;
      rows_q     <= side_t'(MaxSide);
      cols_q     <= side_t'(MaxSide);
      start_q    <= '0;
      end_q      <= cell_t'(MaxCells - 1);
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      clr_q      <= clr_d;
      attempts_q <= attempts_d;
      ov_q       <= ov_d;
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_idx_i))
          REG_GRID_ROWS:  rows_q  <= side_t'(cfg_data_i);
          REG_GRID_COLS:  cols_q  <= side_t'(cfg_data_i);
          REG_START_CELL: start_q <= cell_t'(cfg_data_i);
          REG_END_CELL:   end_q   <= cell_t'(cfg_data_i);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q   <= cell_d;
    dir_q    <= dir_d;
    bad_q    <= bad_d;
    has_q    <= has_d;
    nb_q     <= nb_d;
    find_x_q <= find_x_d;
    root_a_q <= root_a_d;
    pre_q    <= pre_d;
    post_q   <= post_d;
    carved_q <= carved_d;
    if (load_out) begin
      o_carved_q <= carved_q;
      o_cell_q   <= cell_q;
      o_nb_q     <= carved_q ? nb_q : '0;
      o_done_q   <= post_q;
      o_bad_q    <= bad_q;
      o_att_q    <= attempts_q;
    end
  end

  assign in_i.ready           = state_q == S_IDLE;
  assign out_o.valid          = ov_q;
  assign out_o.carved         = o_carved_q;
  assign out_o.chosen_cell    = o_cell_q;
  assign out_o.neighbour_cell = o_nb_q;
  assign out_o.done_res       = o_done_q;
  assign out_o.bad_cell       = o_bad_q;
  assign out_o.attempt_count  = o_att_q;
endmodule
`default_nettype wire
